// ----- rtl/sifr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sifr_pkg;

    typedef logic signed [31:0] t_word;

    // output selection
    localparam logic [1:0] KIND_HOT  = 2'd0;
    localparam logic [1:0] KIND_A    = 2'd1;
    localparam logic [1:0] KIND_B    = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_ADC0     = 3'd0;
    localparam logic [2:0] CFG_ADC1     = 3'd1;
    localparam logic [2:0] CFG_ADC2     = 3'd2;
    localparam logic [2:0] CFG_ADC3     = 3'd3;
    localparam logic [2:0] CFG_LOW_T    = 3'd4;
    localparam logic [2:0] CFG_HIGH_T   = 3'd5;
    localparam logic [2:0] CFG_MIN_DUTY = 3'd6;
    localparam logic [2:0] CFG_MAX_DUTY = 3'd7;

    // temperature nodes, hundredths of a degree
    localparam t_word NODE_T0 = 32'sd2500;
    localparam t_word NODE_T1 = 32'sd5000;
    localparam t_word NODE_T2 = 32'sd8000;
    localparam t_word NODE_T3 = 32'sd12500;

    localparam t_word HOT_DIVISOR  = 32'sd100;
    localparam t_word DUTY_DIVISOR = 32'sd200;
    localparam t_word DUTY_FLOOR   = 32'sd5;

    // job codes: six Neville combinations per sensor, then the fan jobs
    localparam logic [3:0] JOB_P03_A = 4'd0;
    localparam logic [3:0] JOB_P02_A = 4'd1;
    localparam logic [3:0] JOB_P01_A = 4'd2;
    localparam logic [3:0] JOB_Q13_A = 4'd3;
    localparam logic [3:0] JOB_Q12_A = 4'd4;
    localparam logic [3:0] JOB_T_A   = 4'd5;
    localparam logic [3:0] JOB_P03_B = 4'd6;
    localparam logic [3:0] JOB_P02_B = 4'd7;
    localparam logic [3:0] JOB_P01_B = 4'd8;
    localparam logic [3:0] JOB_Q13_B = 4'd9;
    localparam logic [3:0] JOB_Q12_B = 4'd10;
    localparam logic [3:0] JOB_T_B   = 4'd11;
    localparam logic [3:0] JOB_WHOLE = 4'd12;
    localparam logic [3:0] JOB_Q     = 4'd13;
    localparam logic [3:0] JOB_CC    = 4'd14;

    // per-sensor combination step
    localparam logic [2:0] STEP_P03 = 3'd0;
    localparam logic [2:0] STEP_P02 = 3'd1;
    localparam logic [2:0] STEP_P01 = 3'd2;
    localparam logic [2:0] STEP_Q13 = 3'd3;
    localparam logic [2:0] STEP_Q12 = 3'd4;
    localparam logic [2:0] STEP_T   = 3'd5;

    typedef struct packed {
        logic [3:0][11:0] adc;
        logic [14:0]      low_temp;
        logic [14:0]      high_temp;
        logic [7:0]       min_duty;
        logic [7:0]       max_duty;
    } t_cfg;

    typedef struct packed {
        logic  start;
        t_word num;
        t_word den;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quot;
    } t_div_rsp;

    typedef struct packed {
        logic        done;
        t_word       temperature;
        logic [14:0] fan_compare;
    } t_core_rsp;

endpackage

`default_nettype wire

// ----- rtl/sifr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sifr_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire sifr_pkg::t_div_req i_req,
    output sifr_pkg::t_div_rsp   o_rsp
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_q, n_q;
    logic [31:0] r_d, n_d;
    logic        r_neg, n_neg;
    logic        r_zero, n_zero;

    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] trial;

    assign num_mag = i_req.num[31] ? (~i_req.num + 32'd1) : i_req.num;
    assign den_mag = i_req.den[31] ? (~i_req.den + 32'd1) : i_req.den;
    assign trial   = {r_rem, r_q[31]} - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        n_neg  = r_neg;
        n_zero = r_zero;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = num_mag;
            n_d    = den_mag;
            n_neg  = i_req.num[31] ^ i_req.den[31];
            n_zero = (i_req.den == '0);
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial[31:0];
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_q[31]};
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_d    <= n_d;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_zero) begin
            o_rsp.quot = '0;
        end else if (r_neg) begin
            o_rsp.quot = ~r_q + 32'd1;
        end else begin
            o_rsp.quot = r_q;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sifr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sifr_core #(
    parameter int FAN_RATE = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire  [1:0]           i_kind,
    input  wire  [11:0]          i_sensor_a,
    input  wire  [11:0]          i_sensor_b,
    input  wire sifr_pkg::t_cfg  i_cfg,
    input  wire                  i_out_free,
    output logic                 o_idle,
    output sifr_pkg::t_core_rsp  o_rsp
);

    localparam sifr_pkg::t_word RATE_WORD = 32'(FAN_RATE);
    localparam sifr_pkg::t_word DUTY_CEIL = 32'(FAN_RATE / 2 - 5);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_MUL2 = 6'b000100,
        S_DIV  = 6'b001000,
        S_WAIT = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_job, n_job;
    logic [15:0] r_fan_level;

    logic [1:0]  r_kind;
    logic [11:0] r_sa, r_sb;
    sifr_pkg::t_word r_prod, r_acc;
    sifr_pkg::t_word r_p03, r_p02, r_p01, r_q13, r_q12;
    sifr_pkg::t_word r_ta, r_tb, r_whole, r_q, r_cc;

    sifr_pkg::t_div_req div_req;
    sifr_pkg::t_div_rsp div_rsp;

    logic [11:0] x;
    logic [2:0]  step;
    logic [12:0] d0, d1, d2, d3;
    logic [12:0] e01, e02, e03, e12, e13, e23;
    sifr_pkg::t_word a1, b1, a2, b2, den;
    sifr_pkg::t_word mul_a, mul_b;
    sifr_pkg::t_word hot, hot_off, duty_span, thr_span, duty_sel, cc_clamp;
    logic hot_low, hot_high;
    logic [15:0] fan_next;
    sifr_pkg::t_word temp_sel;

    function automatic sifr_pkg::t_word sx13(input logic [12:0] v);
        return {{19{v[12]}}, v};
    endfunction

    assign x    = (r_job < sifr_pkg::JOB_P03_B) ? r_sa : r_sb;
    assign step = (r_job < sifr_pkg::JOB_P03_B) ? r_job[2:0]
                                                : 3'(r_job - sifr_pkg::JOB_P03_B);

    assign d0  = {1'b0, i_cfg.adc[0]} - {1'b0, x};
    assign d1  = {1'b0, i_cfg.adc[1]} - {1'b0, x};
    assign d2  = {1'b0, i_cfg.adc[2]} - {1'b0, x};
    assign d3  = {1'b0, i_cfg.adc[3]} - {1'b0, x};
    assign e01 = {1'b0, i_cfg.adc[0]} - {1'b0, i_cfg.adc[1]};
    assign e02 = {1'b0, i_cfg.adc[0]} - {1'b0, i_cfg.adc[2]};
    assign e03 = {1'b0, i_cfg.adc[0]} - {1'b0, i_cfg.adc[3]};
    assign e12 = {1'b0, i_cfg.adc[1]} - {1'b0, i_cfg.adc[2]};
    assign e13 = {1'b0, i_cfg.adc[1]} - {1'b0, i_cfg.adc[3]};
    assign e23 = {1'b0, i_cfg.adc[2]} - {1'b0, i_cfg.adc[3]};

    assign hot       = (r_ta > r_tb) ? r_ta : r_tb;
    assign hot_low   = hot < $signed({17'd0, i_cfg.low_temp});
    assign hot_high  = hot > $signed({17'd0, i_cfg.high_temp});
    assign hot_off   = hot - $signed({17'd0, i_cfg.low_temp});
    assign duty_span = $signed({24'd0, i_cfg.max_duty}) - $signed({24'd0, i_cfg.min_duty});
    assign thr_span  = $signed({17'd0, i_cfg.high_temp}) - $signed({17'd0, i_cfg.low_temp});

    always_comb begin
        if (hot_low) begin
            duty_sel = {24'd0, i_cfg.min_duty};
        end else if (hot_high) begin
            duty_sel = {24'd0, i_cfg.max_duty};
        end else begin
            duty_sel = r_q + $signed({24'd0, i_cfg.min_duty});
        end
    end

    // operands of the current job: (a1*b1 - a2*b2) / den
    always_comb begin
        a1  = '0;
        b1  = '0;
        a2  = '0;
        b2  = '0;
        den = '0;
        if (r_job < sifr_pkg::JOB_WHOLE) begin
            case (step)
                sifr_pkg::STEP_P03: begin
                    a1 = sifr_pkg::NODE_T3; b1 = sx13(d0);
                    a2 = sifr_pkg::NODE_T0; b2 = sx13(d3); den = sx13(e03);
                end
                sifr_pkg::STEP_P02: begin
                    a1 = sifr_pkg::NODE_T2; b1 = sx13(d0);
                    a2 = sifr_pkg::NODE_T0; b2 = sx13(d2); den = sx13(e02);
                end
                sifr_pkg::STEP_P01: begin
                    a1 = sifr_pkg::NODE_T1; b1 = sx13(d0);
                    a2 = sifr_pkg::NODE_T0; b2 = sx13(d1); den = sx13(e01);
                end
                sifr_pkg::STEP_Q13: begin
                    a1 = r_p03; b1 = sx13(d1);
                    a2 = r_p01; b2 = sx13(d3); den = sx13(e13);
                end
                sifr_pkg::STEP_Q12: begin
                    a1 = r_p02; b1 = sx13(d1);
                    a2 = r_p01; b2 = sx13(d2); den = sx13(e12);
                end
                sifr_pkg::STEP_T: begin
                    a1 = r_q13; b1 = sx13(d2);
                    a2 = r_q12; b2 = sx13(d3); den = sx13(e23);
                end
                default: begin
                    a1 = '0;
                end
            endcase
        end else begin
            case (r_job)
                sifr_pkg::JOB_WHOLE: begin
                    a1 = hot; b1 = 32'sd1; den = sifr_pkg::HOT_DIVISOR;
                end
                sifr_pkg::JOB_Q: begin
                    a1 = hot_off; b1 = duty_span; den = thr_span;
                end
                sifr_pkg::JOB_CC: begin
                    a1 = RATE_WORD; b1 = duty_sel; den = sifr_pkg::DUTY_DIVISOR;
                end
                default: begin
                    a1 = '0;
                end
            endcase
        end
    end

    // one multiplier: a1*b1 in S_MUL1, a2*b2 in S_MUL2
    assign mul_a = (r_state == S_MUL2) ? a2 : a1;
    assign mul_b = (r_state == S_MUL2) ? b2 : b1;

    always_comb begin
        div_req.start = (r_state == S_DIV);
        div_req.num   = r_acc - r_prod;
        div_req.den   = den;
    end

    sifr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_cc < sifr_pkg::DUTY_FLOOR) begin
            cc_clamp = sifr_pkg::DUTY_FLOOR;
        end else if (r_cc > DUTY_CEIL) begin
            cc_clamp = DUTY_CEIL;
        end else begin
            cc_clamp = r_cc;
        end
    end

    assign fan_next = (r_fan_level < cc_clamp[15:0]) ? (r_fan_level + 16'd1)
                                                     : (r_fan_level - 16'd1);

    always_comb begin
        case (r_kind)
            sifr_pkg::KIND_HOT:  temp_sel = r_whole;
            sifr_pkg::KIND_A:    temp_sel = r_ta;
            sifr_pkg::KIND_B:    temp_sel = r_tb;
            sifr_pkg::KIND_NONE: temp_sel = '0;
            default:             temp_sel = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL1;
                    n_job   = sifr_pkg::JOB_P03_A;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DIV;
            S_DIV:  n_state = S_WAIT;
            S_WAIT: begin
                if (div_rsp.done) begin
                    if (r_job == sifr_pkg::JOB_CC) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL1;
                        n_job   = r_job + 4'd1;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= '0;
            r_fan_level <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            if (r_state == S_DONE && i_out_free) begin
                r_fan_level <= fan_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_kind <= i_kind;
            r_sa   <= i_sensor_a;
            r_sb   <= i_sensor_b;
        end
        if (r_state == S_MUL1) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_MUL2) begin
            r_acc  <= r_prod;
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_WAIT && div_rsp.done) begin
            case (r_job)
                sifr_pkg::JOB_P03_A, sifr_pkg::JOB_P03_B: r_p03 <= div_rsp.quot;
                sifr_pkg::JOB_P02_A, sifr_pkg::JOB_P02_B: r_p02 <= div_rsp.quot;
                sifr_pkg::JOB_P01_A, sifr_pkg::JOB_P01_B: r_p01 <= div_rsp.quot;
                sifr_pkg::JOB_Q13_A, sifr_pkg::JOB_Q13_B: r_q13 <= div_rsp.quot;
                sifr_pkg::JOB_Q12_A, sifr_pkg::JOB_Q12_B: r_q12 <= div_rsp.quot;
                sifr_pkg::JOB_T_A:   r_ta    <= div_rsp.quot;
                sifr_pkg::JOB_T_B:   r_tb    <= div_rsp.quot;
                sifr_pkg::JOB_WHOLE: r_whole <= div_rsp.quot;
                sifr_pkg::JOB_Q:     r_q     <= div_rsp.quot;
                sifr_pkg::JOB_CC:    r_cc    <= div_rsp.quot;
                default:             r_cc    <= r_cc;
            endcase
        end
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        o_rsp.done        = (r_state == S_DONE) && i_out_free;
        o_rsp.temperature = temp_sel;
        o_rsp.fan_compare = fan_next[14:0];
    end

`ifndef ASSERT_OFF
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_WAIT)
        else $error("divider finished outside wait state");

    a_job_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job <= sifr_pkg::JOB_CC)
        else $error("job counter out of range");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("start while busy");

    a_fan_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.done |=> $stable(r_fan_level))
        else $error("fan level moved without a result");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> r_state == S_IDLE)
        else $error("sequencer did not return to idle");
`endif

endmodule

`default_nettype wire

// ----- rtl/sensor_interp_fan_ramp_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                  Payload
// input     in   i_in_valid / o_in_stall    i_kind, i_sensor_a, i_sensor_b
// output    out  o_out_valid / i_out_stall  o_temperature, o_fan_compare
// config    in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One transaction runs 15 jobs in turn, each a pair of multiplies on one shared multiplier
// followed by a division on the shared 1-bit-per-cycle divider. The next transaction
// is accepted only once the previous result has been loaded into the output register.
// o_in_stall is high from acceptance until the result is loaded into the output register.
// A waiting result holds in the output register; the next transaction is still accepted.
// Synchronous active-low reset restores the register defaults and clears the fan level.

module sensor_interp_fan_ramp_top #(
    parameter int FAN_RATE = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire  [1:0]   i_kind,
    input  wire  [11:0]  i_sensor_a,
    input  wire  [11:0]  i_sensor_b,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output logic [31:0]  o_temperature,
    output logic [14:0]  o_fan_compare,
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_idx,
    input  wire  [14:0]  i_cfg_data
);

    sifr_pkg::t_cfg      r_cfg;
    sifr_pkg::t_core_rsp core_rsp;
    logic                core_idle;
    logic                out_free;
    logic                r_out_valid;
    logic [31:0]         r_temperature;
    logic [14:0]         r_fan_compare;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adc[0]    <= 12'd1305;
            r_cfg.adc[1]    <= 12'd2250;
            r_cfg.adc[2]    <= 12'd3141;
            r_cfg.adc[3]    <= 12'd3764;
            r_cfg.low_temp  <= 15'd3000;
            r_cfg.high_temp <= 15'd4000;
            r_cfg.min_duty  <= 8'd20;
            r_cfg.max_duty  <= 8'd95;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sifr_pkg::CFG_ADC0:     r_cfg.adc[0]    <= i_cfg_data[11:0];
                sifr_pkg::CFG_ADC1:     r_cfg.adc[1]    <= i_cfg_data[11:0];
                sifr_pkg::CFG_ADC2:     r_cfg.adc[2]    <= i_cfg_data[11:0];
                sifr_pkg::CFG_ADC3:     r_cfg.adc[3]    <= i_cfg_data[11:0];
                sifr_pkg::CFG_LOW_T:    r_cfg.low_temp  <= i_cfg_data;
                sifr_pkg::CFG_HIGH_T:   r_cfg.high_temp <= i_cfg_data;
                sifr_pkg::CFG_MIN_DUTY: r_cfg.min_duty  <= i_cfg_data[7:0];
                sifr_pkg::CFG_MAX_DUTY: r_cfg.max_duty  <= i_cfg_data[7:0];
                default:                r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_in_stall = !core_idle;
    assign out_free   = !r_out_valid || !i_out_stall;

    sifr_core #(
        .FAN_RATE (FAN_RATE)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && core_idle),
        .i_kind     (i_kind),
        .i_sensor_a (i_sensor_a),
        .i_sensor_b (i_sensor_b),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_idle     (core_idle),
        .o_rsp      (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_rsp.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_rsp.done) begin
            r_temperature <= core_rsp.temperature;
            r_fan_compare <= core_rsp.fan_compare;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_temperature = r_temperature;
    assign o_fan_compare = r_fan_compare;

endmodule

`default_nettype wire

// ----- verif/sensor_interp_fan_ramp_top_tb.sv -----
`timescale 1ns / 1ps

module sensor_interp_fan_ramp_top_tb;

    localparam int FAN_RATE    = 1024;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 600;

    typedef struct {
        int          temperature;
        logic [14:0] fan_compare;
    } t_readout;

    class fan_temp_scoreboard;
        int          adc_pt[4];
        int          low_t;
        int          high_t;
        int          min_d;
        int          max_d;
        logic [15:0] fan_level;
        t_readout    expected_q[$];
        int          errors;

        function new();
            adc_pt    = '{1305, 2250, 3141, 3764};
            low_t     = 3000;
            high_t    = 4000;
            min_d     = 20;
            max_d     = 95;
            fan_level = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [14:0] val);
            case (idx)
                sifr_pkg::CFG_ADC0:     adc_pt[0] = val[11:0];
                sifr_pkg::CFG_ADC1:     adc_pt[1] = val[11:0];
                sifr_pkg::CFG_ADC2:     adc_pt[2] = val[11:0];
                sifr_pkg::CFG_ADC3:     adc_pt[3] = val[11:0];
                sifr_pkg::CFG_LOW_T:    low_t = val;
                sifr_pkg::CFG_HIGH_T:   high_t = val;
                sifr_pkg::CFG_MIN_DUTY: min_d = val[7:0];
                sifr_pkg::CFG_MAX_DUTY: max_d = val[7:0];
                default: ;
            endcase
        endfunction

        // (fa*da - fb*db) / den in wrapping 32-bit arithmetic
        function int neville(int fa, int da, int fb, int db, int den);
            int num;
            num = fa * da - fb * db;
            if (den == 0)
                return 0;
            if (num == 32'sh8000_0000 && den == -1)
                return num;
            return num / den;
        endfunction

        function int interp_temp(logic [11:0] reading);
            int x;
            int d[4];
            int p03, p02, p01, q13, q12;
            x = reading;
            for (int k = 0; k < 4; k++)
                d[k] = adc_pt[k] - x;
            p03 = neville(sifr_pkg::NODE_T3, d[0], sifr_pkg::NODE_T0, d[3], d[0] - d[3]);
            p02 = neville(sifr_pkg::NODE_T2, d[0], sifr_pkg::NODE_T0, d[2], d[0] - d[2]);
            p01 = neville(sifr_pkg::NODE_T1, d[0], sifr_pkg::NODE_T0, d[1], d[0] - d[1]);
            q13 = neville(p03, d[1], p01, d[3], d[1] - d[3]);
            q12 = neville(p02, d[1], p01, d[2], d[1] - d[2]);
            return neville(q13, d[2], q12, d[3], d[2] - d[3]);
        endfunction

        function longint fan_target(int hot);
            longint lo, hi, q, cc, hot_l, div_l, floor_l;
            lo      = low_t;
            hi      = high_t;
            hot_l   = hot;
            div_l   = longint'(sifr_pkg::DUTY_DIVISOR);
            floor_l = longint'(sifr_pkg::DUTY_FLOOR);
            if (hot_l < lo) begin
                cc = (longint'(FAN_RATE) * longint'(min_d)) / div_l;
            end else if (hot_l > hi) begin
                cc = (longint'(FAN_RATE) * longint'(max_d)) / div_l;
            end else begin
                if (hi == lo)
                    q = 0;
                else
                    q = ((hot_l - lo) * (longint'(max_d) - longint'(min_d))) / (hi - lo);
                cc = (longint'(FAN_RATE) * (q + longint'(min_d))) / div_l;
            end
            if (cc < floor_l)
                cc = floor_l;
            if (cc > longint'(FAN_RATE / 2) - floor_l)
                cc = longint'(FAN_RATE / 2) - floor_l;
            return cc;
        endfunction

        function void note_reading(logic [1:0] kind, logic [11:0] sa, logic [11:0] sb_in);
            int       ta, tb, hot;
            longint   cc, lvl;
            t_readout r;
            ta  = interp_temp(sa);
            tb  = interp_temp(sb_in);
            hot = (ta > tb) ? ta : tb;
            cc  = fan_target(hot);
            lvl = fan_level;
            if (lvl < cc)
                fan_level = fan_level + 16'd1;
            else
                fan_level = fan_level - 16'd1;
            case (kind)
                sifr_pkg::KIND_HOT: r.temperature = hot / sifr_pkg::HOT_DIVISOR;
                sifr_pkg::KIND_A:   r.temperature = ta;
                sifr_pkg::KIND_B:   r.temperature = tb;
                default:            r.temperature = 0;
            endcase
            r.fan_compare = fan_level[14:0];
            expected_q.push_back(r);
        endfunction

        function void check_readout(logic [31:0] temp, logic [14:0] fan);
            t_readout r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction, temperature %0d fan_compare %0d",
                         $time, $signed(temp), fan);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if ($signed(temp) != r.temperature) begin
                $display("%0t: temperature mismatch, expected %0d, actual %0d",
                         $time, r.temperature, $signed(temp));
                errors++;
            end
            if (fan != r.fan_compare) begin
                $display("%0t: fan_compare mismatch, expected %0d, actual %0d",
                         $time, r.fan_compare, fan);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_kind      = sifr_pkg::KIND_HOT;
    logic [11:0] i_sensor_a  = '0;
    logic [11:0] i_sensor_b  = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_idx   = sifr_pkg::CFG_ADC0;
    logic [14:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_temperature;
    logic [14:0] o_fan_compare;

    fan_temp_scoreboard sb = new();

    logic gaps_on   = 1'b1;
    logic held      = 1'b0;
    int   hold_left = 0;
    int   n_in      = 0;
    int   cycle_count = 0;

    sensor_interp_fan_ramp_top #(
        .FAN_RATE(FAN_RATE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_sensor_a   (i_sensor_a),
        .i_sensor_b   (i_sensor_b),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_temperature(o_temperature),
        .o_fan_compare(o_fan_compare),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_readout(o_temperature, o_fan_compare);
            if (i_in_valid && !o_in_stall) begin
                sb.note_reading(i_kind, i_sensor_a, i_sensor_b);
                n_in <= n_in + 1;
            end
        end
    end

    // output side: random stalls plus one long hold-off to back up the block
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!held && n_in == HOLD_AT) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            held        <= 1'b1;
        end else begin
            i_out_stall <= gaps_on && ($urandom_range(99) < 7);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic [1:0] kind, input logic [11:0] sa,
                             input logic [11:0] sbv);
        while (gaps_on && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_sensor_a <= sa;
        i_sensor_b <= sbv;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[14:0];
        sb.write_reg(idx, val[14:0]);
        @(posedge i_clk);
    endtask

    task automatic program_cfg(input int a0, input int a1, input int a2, input int a3,
                               input int lo, input int hi, input int mn, input int mx);
        write_reg(sifr_pkg::CFG_ADC0, a0);
        write_reg(sifr_pkg::CFG_ADC1, a1);
        write_reg(sifr_pkg::CFG_ADC2, a2);
        write_reg(sifr_pkg::CFG_ADC3, a3);
        write_reg(sifr_pkg::CFG_LOW_T, lo);
        write_reg(sifr_pkg::CFG_HIGH_T, hi);
        write_reg(sifr_pkg::CFG_MIN_DUTY, mn);
        write_reg(sifr_pkg::CFG_MAX_DUTY, mx);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // half uniform, half clustered around the current ADC nodes
    function automatic logic [11:0] pick_reading();
        int v;
        if ($urandom_range(99) < 50)
            return 12'($urandom_range(4095));
        v = sb.adc_pt[$urandom_range(3)] + int'($urandom_range(160)) - 80;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    task automatic run_random(input int count);
        repeat (count)
            send_item(2'($urandom_range(3)), pick_reading(), pick_reading());
        drain();
    endtask

    initial begin
        int a0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(sifr_pkg::KIND_HOT, 12'd0, 12'd0);
        send_item(sifr_pkg::KIND_A, 12'd4095, 12'd0);
        send_item(sifr_pkg::KIND_B, 12'd0, 12'd4095);
        send_item(sifr_pkg::KIND_NONE, 12'd4095, 12'd4095);
        send_item(sifr_pkg::KIND_A, 12'd1305, 12'd2250);
        send_item(sifr_pkg::KIND_B, 12'd3141, 12'd3764);
        send_item(sifr_pkg::KIND_HOT, 12'd3764, 12'd1305);
        send_item(sifr_pkg::KIND_HOT, 12'hAAA, 12'h555);
        send_item(sifr_pkg::KIND_A, 12'h555, 12'hAAA);
        send_item(sifr_pkg::KIND_NONE, 12'd2000, 12'd3000);
        send_item(sifr_pkg::KIND_HOT, 12'd2700, 12'd2701);
        send_item(sifr_pkg::KIND_B, 12'd1, 12'd4094);
        send_item(sifr_pkg::KIND_A, 12'd2048, 12'd2048);
        send_item(sifr_pkg::KIND_HOT, 12'd4094, 12'd1);
        run_random(70);

        // ascending nodes, wide duty span, no idling on either side
        gaps_on <= 1'b0;
        a0 = $urandom_range(1000);
        program_cfg(a0, a0 + $urandom_range(1, 1000), 2000 + $urandom_range(1000),
                    3000 + $urandom_range(1000), 1000, 6000, 0, 200);
        run_random(80);
        gaps_on <= 1'b1;

        // all nodes equal and equal thresholds: every interpolation divisor and the threshold span are zero
        program_cfg(2048, 2048, 2048, 2048, 5000, 5000, 50, 150);
        run_random(50);

        // hot exactly on equal thresholds
        program_cfg(1305, 2250, 3141, 3764, 2500, 2500, 20, 95);
        send_item(sifr_pkg::KIND_HOT, 12'd1305, 12'd1305);
        send_item(sifr_pkg::KIND_A, 12'd1305, 12'd0);
        send_item(sifr_pkg::KIND_B, 12'd0, 12'd1305);
        send_item(sifr_pkg::KIND_HOT, 12'd1304, 12'd1305);
        run_random(40);

        program_cfg(0, 0, 4095, 4095, 0, 20000, 200, 0);
        run_random(60);

        // crossed thresholds
        program_cfg(0, 1365, 2730, 4095, 20000, 0, 0, 200);
        run_random(50);

        repeat (2) begin
            program_cfg($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                        $urandom_range(4095), $urandom_range(20000), $urandom_range(20000),
                        $urandom_range(200), $urandom_range(200));
            run_random(40);
        end

        // target at the floor so the level ramps down
        program_cfg(1305, 2250, 3141, 3764, 3000, 4000, 0, 0);
        run_random(60);

        program_cfg(1305, 2250, 3141, 3764, 3000, 4000, 20, 95);
        run_random(40);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sifr_pkg.sv
rtl/sifr_div.sv
rtl/sifr_core.sv
rtl/sensor_interp_fan_ramp_top.sv
verif/sensor_interp_fan_ramp_top_tb.sv
